// ===== design/rgb_box_blur_5x5_top_assert.svh =====
// Assertion macros shared by the 5x5 box blur RTL.
`ifndef RGB_BOX_BLUR_5X5_TOP_ASSERT_SVH
`define RGB_BOX_BLUR_5X5_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk and disabled while aresetn is low.
`define RBB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and disabled while aresetn is low.
`define RBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rbb_pkg.sv =====
// Types and constants of the 5x5 RGB box blur.
`default_nettype none

package rbb_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 2048;

    localparam int PIX_W       = 8;
    localparam int WIN         = 5;
    localparam int LINES       = WIN - 1;
    localparam int RGB_W       = 3 * PIX_W;
    localparam int LINE_WORD_W = LINES * RGB_W;

    // A column of five 8-bit values sums to at most 1275, the window to 6375.
    localparam int COLSUM_W = 11;
    localparam int WINSUM_W = 13;

    // floor(x / 25) == (x * 5243) >> 17 for every x up to 6375.
    localparam int                  DIV25_SHIFT = 17;
    localparam int                  DIV25_W     = 13;
    localparam logic [DIV25_W-1:0]  DIV25_MUL   = 13'd5243;

    localparam int DIM_W      = 12;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

    // Result queue behind the arithmetic pipeline.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = OUT_PTR_W + 1;

    // Red sits in the lowest bits, matching the stream packing.
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [COLSUM_W-1:0] blue;
        logic [COLSUM_W-1:0] green;
        logic [COLSUM_W-1:0] red;
    } colsum_t;

    typedef struct packed {
        logic [WINSUM_W-1:0] blue;
        logic [WINSUM_W-1:0] green;
        logic [WINSUM_W-1:0] red;
    } winsum_t;

    typedef struct packed {
        logic   last;
        pixel_t mean;
    } result_t;

    // Control that travels with each pixel down the pipeline.
    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } stage_ctl_t;

endpackage

`default_nettype wire

// ===== design/rgb_box_blur_5x5_top.sv =====
// Top level of the streaming 5x5 RGB box blur.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+---------------------------------------
//  s_       | in        | s_tvalid / s_tready        | s_tdata: in_red, in_green, in_blue
//  m_       | out       | m_tvalid / m_tready        | m_tdata: out_red, out_green, out_blue;
//           |           |                            | m_tlast: frame_last
//  cfg_     | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data (12 bits)
//
// One pixel is transferred per clock while m_ keeps up; the line memory does at most
// one read and one write per cycle. A completed window's result passes the ctl1, ctl2
// and ctl3 pipeline registers and enters the result queue before m_tvalid rises.
// Synchronous reset on aresetn low clears the counters, pipeline and result queue and
// loads a 640 x 480 frame; the line memory is not cleared. s_tready falls only while the
// eight-entry queue, with results still in the pipeline counted, is full.
`default_nettype none

`include "rgb_box_blur_5x5_top_assert.svh"

module rgb_box_blur_5x5_top
    import rbb_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [RGB_W-1:0]      s_tdata,    // in_red, in_green, in_blue

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [RGB_W-1:0]           m_tdata,    // out_red, out_green, out_blue
    output logic                       m_tlast,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Column counter indexes the line memory directly; the comparison width
    // covers both the 12-bit registers and the largest line length.
    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam logic [WW-1:0]    MAX_W    = WW'(MAX_LINE_WIDTH);
    localparam logic [WW-1:0]    W_SPAN   = WW'(LINES);
    localparam logic [DIM_W-1:0] H_SPAN   = DIM_W'(LINES);

    // ------------------------------------------------------------------
    // Configuration registers. Users write only while the block is idle; unenforced.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position of the arriving pixel and whether it completes an
    // interior window. A width of zero acts as one, and the width is capped
    // at the line memory length; a height of zero acts as one.
    // ------------------------------------------------------------------
    logic [CW-1:0]    col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [WW-1:0]    fw_ext, w_eff, col_ext;
    logic [DIM_W-1:0] h_eff;
    logic             at_line_end, at_frame_end, in_window, is_last;
    logic             s_accept;

    always_comb begin
        fw_ext = WW'(frame_width_reg);
        if (fw_ext == '0) begin
            w_eff = WW'(1);
        end else if (fw_ext > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = fw_ext;
        end
        h_eff        = (frame_height_reg == '0) ? DIM_W'(1) : frame_height_reg;
        col_ext      = WW'(col_reg);
        at_line_end  = col_ext >= w_eff - WW'(1);
        at_frame_end = row_reg >= h_eff - DIM_W'(1);
        in_window    = (col_ext >= W_SPAN) && (row_reg >= H_SPAN)
                    && (col_ext < w_eff) && (row_reg < h_eff);
        is_last      = (col_ext == w_eff - WW'(1)) && (row_reg == h_eff - DIM_W'(1));

        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (at_line_end) begin
                col_next = '0;
                row_next = at_frame_end ? '0 : row_reg + DIM_W'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control and result queue occupancy.
    // ------------------------------------------------------------------
    stage_ctl_t ctl1_reg, ctl2_reg, ctl3_reg;

    logic [OUT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OUT_CNT_W-1:0] cnt_reg;
    logic [OUT_CNT_W-1:0] credit;
    logic                 fifo_push, fifo_pop, fifo_full;

    // Every result still in the pipeline has a queue slot reserved for it.
    assign credit    = cnt_reg + OUT_CNT_W'(ctl1_reg.emit) + OUT_CNT_W'(ctl2_reg.emit)
                     + OUT_CNT_W'(ctl3_reg.emit);
    assign s_tready  = credit < OUT_CNT_W'(OUT_DEPTH);
    assign s_accept  = s_tvalid && s_tready;
    assign fifo_push = ctl3_reg.valid && ctl3_reg.emit;
    assign fifo_pop  = m_tvalid && m_tready;
    assign fifo_full = cnt_reg == OUT_CNT_W'(OUT_DEPTH);

    // ------------------------------------------------------------------
    // Line memory: one word per column holds the four previous lines,
    // newest in the lowest bits. It is read as the pixel is transferred and
    // written back, shifted by one line, in the following cycle.
    // ------------------------------------------------------------------
    logic [LINE_WORD_W-1:0] line_mem [MAX_LINE_WIDTH];
    logic [LINE_WORD_W-1:0] rd_q_reg;
    logic [LINE_WORD_W-1:0] fwd_data_reg;
    logic                   fwd_sel_reg;
    logic [LINE_WORD_W-1:0] word_s1, wr_word;
    logic [CW-1:0]          col1_reg;
    pixel_t                 px1_reg;
    logic                   fwd_hit;

    // With a one-pixel line the same column is read while it is being
    // written back, so the written word is handed straight to the reader.
    assign fwd_hit = s_accept && ctl1_reg.valid && (col1_reg == col_reg);
    assign word_s1 = fwd_sel_reg ? fwd_data_reg : rd_q_reg;
    assign wr_word = {word_s1[LINE_WORD_W-RGB_W-1:0], px1_reg};

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_q_reg <= line_mem[col_reg];
        end
        if (ctl1_reg.valid) begin
            line_mem[col1_reg] <= wr_word;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sum the new column of five pixels per channel and shift it
    // into the window of column sums.
    // ------------------------------------------------------------------
    function automatic logic [COLSUM_W-1:0] chan_sum(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] c,
        input logic [PIX_W-1:0] d,
        input logic [PIX_W-1:0] e
    );
        chan_sum = COLSUM_W'(a) + COLSUM_W'(b) + COLSUM_W'(c) + COLSUM_W'(d) + COLSUM_W'(e);
    endfunction

    pixel_t  lines_px [LINES];
    colsum_t col_sum;
    colsum_t win_reg [WIN];

    always_comb begin
        for (int i = 0; i < LINES; i++) begin
            lines_px[i] = word_s1[i*RGB_W +: RGB_W];
        end
        col_sum.red   = chan_sum(lines_px[0].red, lines_px[1].red, lines_px[2].red,
                                 lines_px[3].red, px1_reg.red);
        col_sum.green = chan_sum(lines_px[0].green, lines_px[1].green, lines_px[2].green,
                                 lines_px[3].green, px1_reg.green);
        col_sum.blue  = chan_sum(lines_px[0].blue, lines_px[1].blue, lines_px[2].blue,
                                 lines_px[3].blue, px1_reg.blue);
    end

    // ------------------------------------------------------------------
    // Stage 2: add the five column sums. Stage 3: divide by 25 through a
    // reciprocal multiply as the result enters the queue.
    // ------------------------------------------------------------------
    winsum_t win_sum;
    winsum_t sum3_reg;
    result_t out_mem [OUT_DEPTH];
    result_t head;
    pixel_t  mean3;
    logic [WINSUM_W+DIV25_W-1:0] prod_r, prod_g, prod_b;

    always_comb begin
        win_sum = '0;
        for (int i = 0; i < WIN; i++) begin
            win_sum.red   = win_sum.red   + WINSUM_W'(win_reg[i].red);
            win_sum.green = win_sum.green + WINSUM_W'(win_reg[i].green);
            win_sum.blue  = win_sum.blue  + WINSUM_W'(win_reg[i].blue);
        end
        prod_r     = (WINSUM_W+DIV25_W)'(sum3_reg.red)   * (WINSUM_W+DIV25_W)'(DIV25_MUL);
        prod_g     = (WINSUM_W+DIV25_W)'(sum3_reg.green) * (WINSUM_W+DIV25_W)'(DIV25_MUL);
        prod_b     = (WINSUM_W+DIV25_W)'(sum3_reg.blue)  * (WINSUM_W+DIV25_W)'(DIV25_MUL);
        mean3.red   = prod_r[DIV25_SHIFT +: PIX_W];
        mean3.green = prod_g[DIV25_SHIFT +: PIX_W];
        mean3.blue  = prod_b[DIV25_SHIFT +: PIX_W];
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px1_reg  <= pixel_t'(s_tdata);
            col1_reg <= col_reg;
        end
        fwd_data_reg <= wr_word;
        if (ctl1_reg.valid) begin
            for (int i = 0; i < WIN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN-1] <= col_sum;
        end
        sum3_reg <= win_sum;
        if (fifo_push) begin
            out_mem[wr_ptr_reg] <= '{last: ctl3_reg.last, mean: mean3};
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            ctl1_reg    <= '0;
            ctl2_reg    <= '0;
            ctl3_reg    <= '0;
            fwd_sel_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            ctl1_reg    <= '{valid: s_accept, emit: s_accept && in_window,
                             last: s_accept && in_window && is_last};
            ctl2_reg    <= ctl1_reg;
            ctl3_reg    <= ctl2_reg;
            fwd_sel_reg <= fwd_hit;
            if (fifo_push) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (fifo_pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + OUT_CNT_W'(fifo_push) - OUT_CNT_W'(fifo_pop);
        end
    end

    // Result channel is driven from the head of the queue.
    assign head     = out_mem[rd_ptr_reg];
    assign m_tvalid = cnt_reg != '0;
    assign m_tdata  = head.mean;
    assign m_tlast  = head.last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `RBB_ASSERT_NOW(a_queue_no_overflow, fifo_push, !fifo_full || fifo_pop,
        "result queue written while full")
    `RBB_ASSERT_NEXT(a_pipe_flows, ctl2_reg.valid, ctl3_reg.valid,
        "pixel lost between sum and divide stages")
    `RBB_ASSERT_NEXT(a_same_column_forwarded, s_accept && ctl1_reg.valid && (col1_reg == col_reg),
        fwd_sel_reg, "line word of a back-to-back column not forwarded")

endmodule

`default_nettype wire
